@@ design/bfdh_pkg.sv @@
// ----------------------------------------------------------------------------
// bfdh_pkg
// Shared types, constants and helpers of the Bloom filter hashing unit.
// ----------------------------------------------------------------------------
`default_nettype none

package bfdh_pkg;

    localparam int MAX_FILTER_BYTES_DEF = 8192;
    localparam int MAX_HASHES_DEF       = 16;

    localparam logic [63:0] SEED_ONE     = 64'h1234_5678_9ABC_DEF0;
    localparam logic [63:0] SEED_TWO     = 64'hFEDC_BA98_7654_3210;
    localparam logic [8:0]  FNV_PRIME_LO = 9'h1B3;
    localparam int          FNV_SHIFT    = 40;

    localparam int          CFG_IDX_W        = 2;
    localparam int          CFG_DATA_W       = 14;
    localparam logic [1:0]  REG_FILTER_BYTES = 2'd0;
    localparam logic [1:0]  REG_NUM_HASHES   = 2'd1;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    typedef struct packed {
        logic       op;
        logic [7:0] key_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic maybe_present;
        logic was_query;
    } out_item_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_R1_GO,
        S_R1_WAIT,
        S_R2_GO,
        S_R2_WAIT,
        S_RC_GO,
        S_RC_WAIT,
        S_PROBE_RD,
        S_PROBE_WR,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        SEL_H1,
        SEL_H2,
        SEL_WRAP
    } rem_sel_t;

    typedef struct packed {
        logic     clear_step;
        logic     hash_update;
        logic     hash_reset;
        logic     rem_start;
        rem_sel_t rem_sel;
        logic     probe_init;
        logic     probe_read;
        logic     probe_apply;
        logic     result_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic rem_done;
        logic zero_hashes;
        logic last_probe;
    } ctrl_status_t;

    function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
        logic [63:0] x;
        x = h ^ {56'd0, b};
        return (x << FNV_SHIFT) + (x * {55'd0, FNV_PRIME_LO});
    endfunction

endpackage

`default_nettype wire

@@ design/bfdh_rem.sv @@
// ----------------------------------------------------------------------------
// bfdh_rem
// Bit-serial remainder unit: reduces a 65-bit value modulo the filter size in bits.
// ----------------------------------------------------------------------------
`default_nettype none

module bfdh_rem #(
    parameter int BW = 17
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [64:0]   dividend,
    input  wire logic [BW-1:0] modulus,
    output logic               done,
    output logic [BW-1:0]      rem
);

    logic [64:0]   dvd_reg, dvd_next;
    logic [BW-1:0] r_reg, r_next;
    logic [6:0]    cnt_reg, cnt_next;
    logic          run_reg, run_next;
    logic          done_reg, done_next;
    logic [BW:0]   trial;

    always_comb
    begin
        trial     = {r_reg, dvd_reg[64]};
        dvd_next  = dvd_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            dvd_next = dividend;
            r_next   = '0;
            cnt_next = 7'd65;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            dvd_next = {dvd_reg[63:0], 1'b0};
            if (trial >= {1'b0, modulus})
            begin
                r_next = BW'(trial - {1'b0, modulus});
            end
            else
            begin
                r_next = BW'(trial);
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        r_reg   <= r_next;
    end

    assign done = done_reg;
    assign rem  = r_reg;

endmodule

`default_nettype wire

@@ design/bfdh_ctrl.sv @@
// ----------------------------------------------------------------------------
// bfdh_ctrl
// Sequencer: store clearing, key intake, reductions and probe loop.
// ----------------------------------------------------------------------------
`default_nettype none

module bfdh_ctrl
    import bfdh_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic         last_byte,
    input  wire ctrl_status_t status,
    output ctrl_cmd_t         cmd,
    output logic              busy
);

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:    if (status.clear_done) state_next = S_IDLE;
            S_IDLE:     if (start && last_byte) state_next = S_R1_GO;
            S_R1_GO:    state_next = S_R1_WAIT;
            S_R1_WAIT:  if (status.rem_done) state_next = S_R2_GO;
            S_R2_GO:    state_next = S_R2_WAIT;
            S_R2_WAIT:  if (status.rem_done) state_next = S_RC_GO;
            S_RC_GO:    state_next = S_RC_WAIT;
            S_RC_WAIT:
            begin
                if (status.rem_done)
                begin
                    state_next = status.zero_hashes ? S_DONE : S_PROBE_RD;
                end
            end
            S_PROBE_RD: state_next = S_PROBE_WR;
            S_PROBE_WR: state_next = status.last_probe ? S_DONE : S_PROBE_RD;
            S_DONE:     state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd         = '0;
        cmd.rem_sel = SEL_H1;
        case (state_reg)
            S_CLEAR:    cmd.clear_step = 1'b1;
            S_IDLE:     cmd.hash_update = start;
            S_R1_GO:
            begin
                cmd.rem_start = 1'b1;
                cmd.rem_sel   = SEL_H1;
            end
            S_R1_WAIT:  cmd.rem_sel = SEL_H1;
            S_R2_GO:
            begin
                cmd.rem_start = 1'b1;
                cmd.rem_sel   = SEL_H2;
            end
            S_R2_WAIT:  cmd.rem_sel = SEL_H2;
            S_RC_GO:
            begin
                cmd.rem_start = 1'b1;
                cmd.rem_sel   = SEL_WRAP;
            end
            S_RC_WAIT:
            begin
                cmd.rem_sel    = SEL_WRAP;
                cmd.probe_init = status.rem_done;
            end
            S_PROBE_RD: cmd.probe_read = 1'b1;
            S_PROBE_WR: cmd.probe_apply = 1'b1;
            S_DONE:
            begin
                cmd.result_out = 1'b1;
                cmd.hash_reset = 1'b1;
            end
            default:    cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

`default_nettype wire

@@ design/bfdh_dp.sv @@
// ----------------------------------------------------------------------------
// bfdh_dp
// Datapath: configuration, running hashes, probe positions and bit store.
// ----------------------------------------------------------------------------
`default_nettype none

module bfdh_dp
    import bfdh_pkg::*;
#(
    parameter int MAX_FILTER_BYTES = MAX_FILTER_BYTES_DEF,
    parameter int MAX_HASHES       = MAX_HASHES_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire ctrl_cmd_t             cmd,
    input  wire in_item_t              item,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output ctrl_status_t               status,
    output logic                       result_valid,
    output out_item_t                  result
);

    localparam int FBW = $clog2(MAX_FILTER_BYTES + 1);
    localparam int UW  = (FBW > CFG_DATA_W) ? FBW : CFG_DATA_W;
    localparam int BW  = FBW + 3;
    localparam int AW  = (MAX_FILTER_BYTES > 1) ? $clog2(MAX_FILTER_BYTES) : 1;
    localparam int KW  = $clog2(MAX_HASHES + 1);

    logic [CFG_DATA_W-1:0] fbytes_reg;
    logic [4:0]            nhash_reg;
    logic [63:0]           h1_reg, h2_reg, sum_reg;
    logic                  op_reg, all_set_reg;
    logic [BW-1:0]         hm1_reg, hm2_reg, wrap_reg, pos_reg, pos_next;
    logic [KW-1:0]         cnt_reg;
    logic [AW-1:0]         clr_reg;
    logic [7:0]            rd_reg;
    logic [7:0]            mem [MAX_FILTER_BYTES];
    logic                  res_valid_reg;
    out_item_t             res_reg;

    logic [UW-1:0]  used_bytes;
    logic [BW-1:0]  modulus;
    logic [KW-1:0]  k_used;
    logic [64:0]    dividend;
    logic [BW-1:0]  rem;
    logic           rem_done;
    logic [64:0]    sum_wide;
    logic [BW:0]    acc;
    logic [BW-1:0]  acc_mod;
    logic [AW-1:0]  byte_addr;
    logic [7:0]     bit_mask;
    logic           mem_we;
    logic [AW-1:0]  mem_addr;
    logic [7:0]     mem_wdata;

    always_comb
    begin
        used_bytes = UW'(fbytes_reg);
        if (used_bytes == '0)
        begin
            used_bytes = UW'(1);
        end
        else if (used_bytes > UW'(MAX_FILTER_BYTES))
        begin
            used_bytes = UW'(MAX_FILTER_BYTES);
        end
        modulus = BW'(used_bytes) << 3;
        if ({{KW{1'b0}}, nhash_reg} > (KW + 5)'(MAX_HASHES))
        begin
            k_used = KW'(MAX_HASHES);
        end
        else
        begin
            k_used = KW'(nhash_reg);
        end
    end

    always_comb
    begin
        case (cmd.rem_sel)
            SEL_H1:   dividend = {1'b0, h1_reg};
            SEL_H2:   dividend = {1'b0, h2_reg};
            SEL_WRAP: dividend = {1'b1, 64'd0};
            default:  dividend = '0;
        endcase
    end

    bfdh_rem #(
        .BW(BW)
    ) u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.rem_start),
        .dividend (dividend),
        .modulus  (modulus),
        .done     (rem_done),
        .rem      (rem)
    );

    // The running sum wraps at 2^64; a carry out removes 2^64 mod m from the residue.
    always_comb
    begin
        sum_wide = {1'b0, sum_reg} + {1'b0, h2_reg};
        acc      = {1'b0, pos_reg} + {1'b0, hm2_reg};
        if (acc >= {1'b0, modulus})
        begin
            acc = acc - {1'b0, modulus};
        end
        acc_mod = BW'(acc);
        if (sum_wide[64])
        begin
            if (acc_mod >= wrap_reg)
            begin
                pos_next = acc_mod - wrap_reg;
            end
            else
            begin
                pos_next = acc_mod + modulus - wrap_reg;
            end
        end
        else
        begin
            pos_next = acc_mod;
        end
    end

    always_comb
    begin
        byte_addr = AW'(pos_reg >> 3);
        bit_mask  = 8'd1 << pos_reg[2:0];
        mem_we    = cmd.clear_step || (cmd.probe_apply && (op_reg == OP_INSERT));
        mem_addr  = cmd.clear_step ? clr_reg : byte_addr;
        mem_wdata = cmd.clear_step ? 8'd0 : (rd_reg | bit_mask);
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        if (cmd.probe_read)
        begin
            rd_reg <= mem[byte_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fbytes_reg    <= CFG_DATA_W'(8192);
            nhash_reg     <= 5'd7;
            h1_reg        <= SEED_ONE;
            h2_reg        <= SEED_TWO;
            clr_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && (cfg_index == REG_FILTER_BYTES))
            begin
                fbytes_reg <= cfg_data;
            end
            if (cfg_we && (cfg_index == REG_NUM_HASHES))
            begin
                nhash_reg <= cfg_data[4:0];
            end
            if (cmd.hash_update)
            begin
                h1_reg <= fnv_step(h1_reg, item.key_byte);
                h2_reg <= fnv_step(h2_reg, item.key_byte);
            end
            else if (cmd.hash_reset)
            begin
                h1_reg <= SEED_ONE;
                h2_reg <= SEED_TWO;
            end
            if (cmd.clear_step)
            begin
                clr_reg <= clr_reg + AW'(1);
            end
            res_valid_reg <= cmd.result_out;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.hash_update)
        begin
            op_reg <= item.op;
        end
        if (rem_done)
        begin
            case (cmd.rem_sel)
                SEL_H1:   hm1_reg <= rem;
                SEL_H2:   hm2_reg <= rem;
                SEL_WRAP: wrap_reg <= rem;
                default:  wrap_reg <= rem;
            endcase
        end
        if (cmd.rem_start && (cmd.rem_sel == SEL_H1))
        begin
            all_set_reg <= 1'b1;
        end
        if (cmd.probe_init)
        begin
            pos_reg <= hm1_reg;
            sum_reg <= h1_reg;
            cnt_reg <= '0;
        end
        else if (cmd.probe_apply)
        begin
            if ((op_reg == OP_QUERY) && ((rd_reg & bit_mask) == 8'd0))
            begin
                all_set_reg <= 1'b0;
            end
            pos_reg <= pos_next;
            sum_reg <= sum_wide[63:0];
            cnt_reg <= cnt_reg + KW'(1);
        end
        if (cmd.result_out)
        begin
            res_reg.maybe_present <= (op_reg == OP_QUERY) ? all_set_reg : 1'b1;
            res_reg.was_query     <= op_reg;
        end
    end

    assign status.clear_done  = (clr_reg == AW'(MAX_FILTER_BYTES - 1));
    assign status.rem_done    = rem_done;
    assign status.zero_hashes = (k_used == '0);
    assign status.last_probe  = ({1'b0, cnt_reg} + (KW + 1)'(1)) == {1'b0, k_used};
    assign result_valid       = res_valid_reg;
    assign result             = res_reg;

endmodule

`default_nettype wire

@@ design/bloom_filter_fnv_double_hash_unit.sv @@
// ----------------------------------------------------------------------------
// bloom_filter_fnv_double_hash_unit
// Bloom filter over byte-serial keys with two FNV-1a hashes and double hashing.
// ----------------------------------------------------------------------------
// After reset the unit clears its bit store with busy high. A key byte that is
// not the last one is taken without raising busy. The last byte keeps busy high
// through three bit-serial reductions (a start, 65 shift steps and a done each),
// a read and a write for each of num_hashes probes (capped at MAX_HASHES), and a
// step to post the result, which appears in the cycle in which busy falls. Each
// result is shown for one cycle with result_valid high and cannot be stalled, so
// the receiver must take every transfer as it comes.
`default_nettype none

module bloom_filter_fnv_double_hash_unit
    import bfdh_pkg::*;
#(
    parameter int MAX_FILTER_BYTES = MAX_FILTER_BYTES_DEF,
    parameter int MAX_HASHES       = MAX_HASHES_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire in_item_t              item,
    output logic                       result_valid,
    output out_item_t                  result,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    ctrl_cmd_t    cmd;
    ctrl_status_t status;

    bfdh_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .last_byte (item.last_byte),
        .status    (status),
        .cmd       (cmd),
        .busy      (busy)
    );

    bfdh_dp #(
        .MAX_FILTER_BYTES (MAX_FILTER_BYTES),
        .MAX_HASHES       (MAX_HASHES)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .item         (item),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .status       (status),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Bloom filter hashing unit. Keys are sent one byte
// per transfer, and each finished key is predicted with two FNV-1a hashes and
// double hashing into a private copy of the bit store. The bench runs under
// several register settings and random idle gaps on the command side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top
    import bfdh_pkg::*;
();

    class bloom_scoreboard;
        bit          store_bits [0:65535];
        logic [63:0] hash_a;
        logic [63:0] hash_b;
        logic [13:0] filter_bytes;
        logic [4:0]  num_hashes;
        out_item_t   pending_answers [$];
        int          errors;

        function void reset_state();
            foreach (store_bits[i]) store_bits[i] = 1'b0;
            hash_a       = SEED_ONE;
            hash_b       = SEED_TWO;
            filter_bytes = 14'd8192;
            num_hashes   = 5'd7;
            errors       = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [13:0] value);
            if (idx == REG_FILTER_BYTES)
                filter_bytes = value;
            else if (idx == REG_NUM_HASHES)
                num_hashes = value[4:0];
        endfunction

        function void add_transfer(in_item_t it);
            logic [63:0] prime;
            logic [63:0] modulus;
            logic [63:0] pos;
            int          used_k;
            bit          all_set;
            out_item_t   ans;
            prime  = 64'd1099511628211;
            hash_a = (hash_a ^ {56'd0, it.key_byte}) * prime;
            hash_b = (hash_b ^ {56'd0, it.key_byte}) * prime;
            if (!it.last_byte)
                return;
            modulus = (filter_bytes == 0) ? 64'd1 : {50'd0, filter_bytes};
            if (modulus > 64'd8192)
                modulus = 64'd8192;
            modulus = modulus * 8;
            used_k  = (num_hashes > 16) ? 16 : int'(num_hashes);
            all_set = 1'b1;
            for (int i = 0; i < used_k; i++)
            begin
                pos = (hash_a + 64'(i) * hash_b) % modulus;
                if (it.op == OP_QUERY)
                begin
                    if (!store_bits[pos[15:0]])
                        all_set = 1'b0;
                end
                else
                    store_bits[pos[15:0]] = 1'b1;
            end
            hash_a = SEED_ONE;
            hash_b = SEED_TWO;
            ans.maybe_present = (it.op == OP_QUERY) ? all_set : 1'b1;
            ans.was_query     = it.op;
            pending_answers.push_back(ans);
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (pending_answers.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %b", $time, got);
                errors++;
                return;
            end
            want = pending_answers.pop_front();
            if (got.maybe_present !== want.maybe_present)
            begin
                $display("%0t: maybe_present mismatch, expected %b, actual %b",
                         $time, want.maybe_present, got.maybe_present);
                errors++;
            end
            if (got.was_query !== want.was_query)
            begin
                $display("%0t: was_query mismatch, expected %b, actual %b",
                         $time, want.was_query, got.was_query);
                errors++;
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    in_item_t          item;
    logic              result_valid;
    out_item_t         result;
    logic              cfg_we;
    logic [1:0]        cfg_index;
    logic [13:0]       cfg_data;

    bloom_scoreboard   sb;
    logic [63:0]       known_keys [$];
    int                known_lens [$];
    int                sent_items;

    bloom_filter_fnv_double_hash_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result_valid (result_valid),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid)
            sb.check_result(result);
    end

    task automatic idle_gap();
        int r;
        int n;
        r = $urandom_range(0, 99);
        if (r < 65)
            n = 0;
        else if (r < 93)
            n = $urandom_range(1, 3);
        else
            n = $urandom_range(10, 60);
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic send_byte(logic op, logic [7:0] b, logic last);
        in_item_t it;
        it.op        = op;
        it.key_byte  = b;
        it.last_byte = last;
        idle_gap();
        start <= 1'b1;
        item  <= it;
        do @(posedge clk); while (busy);
        sb.add_transfer(it);
        sent_items++;
    endtask

    task automatic send_key(logic op, logic [63:0] key, int len);
        for (int i = 0; i < len; i++)
            send_byte(op, key[8*i +: 8], i == len - 1);
    endtask

    task automatic send_new_key(logic op);
        logic [63:0] key;
        int          len;
        key = {$urandom, $urandom};
        len = $urandom_range(1, 8);
        send_key(op, key, len);
        if (op == OP_INSERT)
        begin
            known_keys.push_back(key);
            known_lens.push_back(len);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending_answers.size() != 0) @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [13:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.write_reg(idx, value);
    endtask

    task automatic random_phase(int count);
        int r;
        int k;
        int stop_at;
        stop_at = sent_items + count;
        while (sent_items < stop_at)
        begin
            r = $urandom_range(0, 99);
            if (r < 45)
                send_new_key(OP_INSERT);
            else if (r < 75 && known_keys.size() != 0)
            begin
                k = $urandom_range(0, known_keys.size() - 1);
                send_key(OP_QUERY, known_keys[k], known_lens[k]);
            end
            else if (r < 95)
                send_new_key(OP_QUERY);
            else
                send_key(1'($urandom_range(0, 1)), {$urandom, $urandom},
                         $urandom_range(9, 16) % 9 + 1);
        end
        drain();
    endtask

    initial
    begin
        sb = new();
        sb.reset_state();
        sent_items = 0;
        rst_n     = 1'b0;
        start     = 1'b0;
        item      = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_key(OP_QUERY, 64'h00, 1);
        send_key(OP_INSERT, 64'h00, 1);
        send_key(OP_QUERY, 64'h00, 1);
        send_key(OP_INSERT, 64'hFF, 1);
        send_key(OP_QUERY, 64'hFF, 1);
        send_key(OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 8);
        send_key(OP_QUERY, 64'hFFFF_FFFF_FFFF_FFFF, 8);
        send_key(OP_QUERY, 64'h0000_0000_0000_0000, 8);
        send_byte(OP_INSERT, 8'hA5, 1'b0);
        send_byte(OP_QUERY, 8'h5A, 1'b1);
        drain();

        write_reg(REG_NUM_HASHES, 14'd0);
        write_reg(2'd2, 14'd3);
        write_reg(2'd3, 14'd1);
        send_key(OP_QUERY, 64'h1234, 2);
        send_key(OP_INSERT, 64'h77, 1);
        send_key(OP_QUERY, 64'h77, 1);
        drain();

        write_reg(REG_FILTER_BYTES, 14'd0);
        write_reg(REG_NUM_HASHES, 14'h3FE0 | 14'd1);
        send_key(OP_QUERY, 64'h42, 1);
        send_key(OP_INSERT, 64'h42, 1);
        send_key(OP_QUERY, 64'h42, 1);
        drain();

        write_reg(REG_FILTER_BYTES, 14'd16383);
        write_reg(REG_NUM_HASHES, 14'd31);
        random_phase(90);

        write_reg(REG_FILTER_BYTES, 14'd8192);
        write_reg(REG_NUM_HASHES, 14'd7);
        random_phase(110);

        write_reg(REG_FILTER_BYTES, 14'd1);
        write_reg(REG_NUM_HASHES, 14'd1);
        random_phase(60);

        write_reg(REG_FILTER_BYTES, 14'd5);
        write_reg(REG_NUM_HASHES, 14'd3);
        random_phase(80);

        write_reg(REG_FILTER_BYTES, 14'd200);
        write_reg(REG_NUM_HASHES, 14'd16);
        random_phase(80);

        write_reg(REG_FILTER_BYTES, 14'd0);
        write_reg(REG_NUM_HASHES, 14'd0);
        random_phase(30);

        write_reg(REG_FILTER_BYTES, 14'd4097);
        write_reg(REG_NUM_HASHES, 14'd20);
        random_phase(60);

        if (sb.errors == 0 && sb.pending_answers.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("simulation failed");
        $finish;
    end

endmodule
